@@ rtl/tmpg_pkg.sv @@
// Shared types and constants of the text-mode pixel generator.
// Depends on nothing; every other file of the block imports it.
package tmpg_pkg;

  localparam int TEXT_COLUMNS  = 40;
  localparam int TEXT_ROWS     = 30;
  localparam int RASTER_W      = TEXT_COLUMNS * 8;
  localparam int RASTER_H      = TEXT_ROWS * 8;
  localparam int CELL_COUNT    = TEXT_COLUMNS * TEXT_ROWS;
  localparam int CELL_AW       = $clog2(CELL_COUNT);
  localparam int WADDR_W       = 11;
  localparam int ITEM_AW       = (CELL_AW > WADDR_W) ? CELL_AW : WADDR_W;
  localparam int FONT_DEPTH    = 2048;
  localparam int FONT_AW       = $clog2(FONT_DEPTH);
  localparam int PALETTE_DEPTH = 16;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int SX_W          = $clog2(RASTER_W + 1);
  localparam int SY_W          = $clog2(RASTER_H + 1);
  localparam int BLINK_W       = 5;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QP_W          = $clog2(QUEUE_DEPTH);
  localparam int QC_W          = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_TEXT    = 2'd0,
    OP_FONT    = 2'd1,
    OP_PALETTE = 2'd2,
    OP_TICK    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_CURSOR_ENABLE = 3'd0,
    CFG_CURSOR_COLUMN = 3'd1,
    CFG_CURSOR_ROW    = 3'd2,
    CFG_CURSOR_FIRST  = 3'd3,
    CFG_CURSOR_LAST   = 3'd4,
    CFG_CURSOR_COLOUR = 3'd5,
    CFG_SWAP_RED_BLUE = 3'd6
  } cfg_index_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [WADDR_W-1:0]  write_address;
    logic [31:0]         write_value;
  } in_req_t;

  typedef struct packed {
    logic [31:0] pixel_colour;
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic        frame_last;
  } pixel_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] column;
    logic [7:0] row;
    logic [2:0] first_line;
    logic [2:0] last_line;
    logic [3:0] colour;
  } cursor_cfg_t;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    opcode_t            kind;
    logic [ITEM_AW-1:0] addr;
    logic [31:0]        value;
    logic [2:0]         glyph_line;
    logic [2:0]         glyph_col;
    logic               cursor_hit;
    logic [8:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic               frame_last;
  } item_t;

endpackage

@@ rtl/tmpg_front.sv @@
// Front end: accepts requests, drops out-of-range writes, runs the raster
// scan and cursor blink, and pushes classified items. Uses tmpg_pkg.
module tmpg_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tmpg_pkg::in_req_t     in_data,
  input  tmpg_pkg::cursor_cfg_t cursor,
  input  logic                  queue_full,
  output logic                  push,
  output tmpg_pkg::item_t       item
);
  import tmpg_pkg::*;

  logic [SX_W-1:0]    scan_x, scan_x_next;
  logic [SY_W-1:0]    scan_y, scan_y_next;
  logic [BLINK_W-1:0] blink_count, blink_count_next;
  logic               cursor_shown, cursor_shown_next;
  logic               accept, is_tick, keep, frame_start, x_last, y_last;
  logic               shown_now, cursor_valid;
  logic [SX_W-4:0]    col;
  logic [SY_W-4:0]    row;
  logic [ITEM_AW-1:0] cell_addr, waddr;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_tick  = (in_data.opcode == OP_TICK);

  assign col         = scan_x[SX_W-1:3];
  assign row         = scan_y[SY_W-1:3];
  assign frame_start = (scan_x == '0) && (scan_y == '0);
  assign x_last      = (scan_x == SX_W'(RASTER_W - 1));
  assign y_last      = (scan_y == SY_W'(RASTER_H - 1));
  assign cell_addr   = ITEM_AW'(col) + ITEM_AW'(row) * ITEM_AW'(TEXT_COLUMNS);
  assign waddr       = ITEM_AW'(in_data.write_address);

  always_comb begin
    blink_count_next  = blink_count;
    cursor_shown_next = cursor_shown;
    if (frame_start) begin
      if (cursor.enable) begin
        cursor_shown_next = (blink_count < BLINK_W'(8));
        if (blink_count < BLINK_W'(8)) begin
          blink_count_next = blink_count + BLINK_W'(1);
        end else if (blink_count < BLINK_W'(16)) begin
          blink_count_next = blink_count + BLINK_W'(2);
        end else begin
          blink_count_next = '0;
        end
      end else begin
        cursor_shown_next = 1'b0;
      end
    end
    shown_now = cursor_shown_next;
  end

  always_comb begin
    scan_x_next = x_last ? '0 : scan_x + SX_W'(1);
    scan_y_next = scan_y;
    if (x_last) begin
      scan_y_next = y_last ? '0 : scan_y + SY_W'(1);
    end
  end

  assign cursor_valid = shown_now && cursor.enable
                     && (cursor.row < 8'(TEXT_ROWS))
                     && (cursor.column < 8'(TEXT_COLUMNS))
                     && (cursor.first_line <= cursor.last_line);

  always_comb begin
    case (in_data.opcode)
      OP_TEXT:    keep = (waddr < ITEM_AW'(CELL_COUNT));
      OP_FONT:    keep = 1'b1;
      OP_PALETTE: keep = (in_data.write_address < WADDR_W'(PALETTE_DEPTH));
      OP_TICK:    keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

  always_comb begin
    item.kind       = in_data.opcode;
    item.addr       = is_tick ? cell_addr : waddr;
    item.value      = in_data.write_value;
    item.glyph_line = scan_y[2:0];
    item.glyph_col  = scan_x[2:0];
    item.cursor_hit = cursor_valid
                   && (8'(row) == cursor.row) && (8'(col) == cursor.column)
                   && (scan_y[2:0] >= cursor.first_line)
                   && (scan_y[2:0] <= cursor.last_line);
    item.pixel_x    = 9'(scan_x);
    item.pixel_y    = 8'(scan_y);
    item.frame_last = x_last && y_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_x       <= '0;
      scan_y       <= '0;
      blink_count  <= '0;
      cursor_shown <= 1'b0;
    end else if (accept && is_tick) begin
      scan_x       <= scan_x_next;
      scan_y       <= scan_y_next;
      blink_count  <= blink_count_next;
      cursor_shown <= cursor_shown_next;
    end
  end

endmodule

@@ rtl/tmpg_queue.sv @@
// Short FIFO of classified items between the front and back ends.
// Uses tmpg_pkg for the item type and depth.
module tmpg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tmpg_pkg::item_t push_item,
  input  logic            pop,
  output tmpg_pkg::item_t head,
  output logic            empty,
  output logic            full
);
  import tmpg_pkg::*;

  item_t           entries [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr, rd_ptr;
  logic [QC_W-1:0] count;
  logic            do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == QC_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QP_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QC_W'(1);
        2'b01:   count <= count - QC_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/tmpg_back.sv @@
// Back end: three chained store reads (text, font, palette) with each store
// written in the stage that reads it, ending in the output register. Uses tmpg_pkg.
module tmpg_back (
  input  logic             clk,
  input  logic             rst,
  input  tmpg_pkg::item_t  head,
  input  logic             queue_empty,
  output logic             pop,
  input  logic             swap_red_blue,
  output logic             out_valid,
  input  logic             out_ready,
  output tmpg_pkg::pixel_t out_data
);
  import tmpg_pkg::*;

  logic [15:0] text_mem    [CELL_COUNT];
  logic [7:0]  font_mem    [FONT_DEPTH];
  logic [31:0] palette_mem [PALETTE_DEPTH];

  logic        advance;
  logic        s1_valid, s2_valid, s3_valid;
  item_t       s1, s2;
  logic [15:0] text_rd;
  logic [7:0]  font_rd;
  logic [31:0] pal_rd;
  logic [3:0]  s2_ink, s2_paper, pal_idx;
  logic [8:0]  s3_x;
  logic [7:0]  s3_y;
  logic        s3_last;
  logic        s1_tick, s2_tick;

  assign advance = !s3_valid || out_ready;
  assign pop     = advance && !queue_empty;
  assign s1_tick = s1_valid && (s1.kind == OP_TICK);
  assign s2_tick = s2_valid && (s2.kind == OP_TICK);

  // Text store: written and read at the queue head.
  always_ff @(posedge clk) begin
    if (pop && head.kind == OP_TEXT) begin
      text_mem[head.addr[CELL_AW-1:0]] <= head.value[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == OP_TICK) begin
      text_rd <= text_mem[head.addr[CELL_AW-1:0]];
    end
  end

  // Font store: second stage.
  always_ff @(posedge clk) begin
    if (advance && s1_valid && s1.kind == OP_FONT) begin
      font_mem[s1.addr[FONT_AW-1:0]] <= s1.value[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_tick) begin
      font_rd  <= font_mem[{text_rd[7:0], s1.glyph_line}];
      s2_ink   <= text_rd[11:8];
      s2_paper <= text_rd[15:12];
    end
  end

  // Palette store: third stage. Font bit 7 is the leftmost pixel.
  always_comb begin
    if (s2.cursor_hit) begin
      pal_idx = s2.value[3:0];
    end else begin
      pal_idx = font_rd[~s2.glyph_col] ? s2_ink : s2_paper;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid && s2.kind == OP_PALETTE) begin
      palette_mem[s2.addr[PAL_AW-1:0]] <= s2.value;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_tick) begin
      pal_rd  <= palette_mem[pal_idx];
      s3_x    <= s2.pixel_x;
      s3_y    <= s2.pixel_y;
      s3_last <= s2.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= head;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_tick;
    end
  end

  assign out_valid             = s3_valid;
  assign out_data.pixel_colour = swap_red_blue
                               ? {pal_rd[31:24], pal_rd[7:0], pal_rd[15:8], pal_rd[23:16]}
                               : pal_rd;
  assign out_data.pixel_x      = s3_x;
  assign out_data.pixel_y      = s3_y;
  assign out_data.frame_last   = s3_last;

endmodule

@@ rtl/text_mode_pixel_generator.sv @@
// Top level of the text-mode pixel generator: configuration registers,
// front end, item queue and back end. Uses tmpg_pkg and all tmpg_* modules.

// Text-mode pixel generator for a 40x30 grid of 8x8 character cells (320x240
// pixels). Requests on the input channel either load the text, font or palette
// stores or, as a pixel tick, produce one pixel in raster order on the output
// channel. The block sustains one request per clock cycle as long as the
// output side takes pixels; a tick passes through the queue and then the
// chain of text, font and palette reads to reach the output, each one a
// registered memory read. Each store is written in the pipeline stage that
// reads it, so loads and ticks take effect strictly in request order. A
// four-entry queue separates the front end from the pipeline, so a stalled
// output holds the pipeline while the front keeps accepting until the queue
// fills. Out-of-range text and palette writes are accepted and dropped. The
// stores have no reset: every entry must be loaded before a tick reads it.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while no request is in flight; index 7 is ignored.
module text_mode_pixel_generator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmpg_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tmpg_pkg::pixel_t  out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import tmpg_pkg::*;

  cursor_cfg_t cursor;
  logic        swap_red_blue;
  logic        queue_push, queue_pop, queue_empty, queue_full;
  item_t       push_item, head_item;

  // Configuration registers. Values are masked to each register's width.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor.enable     <= 1'b0;
      cursor.column     <= '0;
      cursor.row        <= '0;
      cursor.first_line <= '0;
      cursor.last_line  <= 3'd7;
      cursor.colour     <= '0;
      swap_red_blue     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CURSOR_ENABLE: cursor.enable     <= cfg_data[0];
        CFG_CURSOR_COLUMN: cursor.column     <= cfg_data;
        CFG_CURSOR_ROW:    cursor.row        <= cfg_data;
        CFG_CURSOR_FIRST:  cursor.first_line <= cfg_data[2:0];
        CFG_CURSOR_LAST:   cursor.last_line  <= cfg_data[2:0];
        CFG_CURSOR_COLOUR: cursor.colour     <= cfg_data[3:0];
        CFG_SWAP_RED_BLUE: swap_red_blue     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The front end runs the scan and blink counters and classifies each request.
  tmpg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cursor     (cursor),
    .queue_full (queue_full),
    .push       (queue_push),
    .item       (push_item)
  );

  tmpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (queue_push),
    .push_item (push_item),
    .pop       (queue_pop),
    .head      (head_item),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  // The back end reuses the item's value field to carry the cursor colour
  // for ticks, since a tick has no write data of its own.
  item_t back_item;

  always_comb begin
    back_item = head_item;
    if (head_item.kind == OP_TICK) begin
      back_item.value = {28'd0, cursor.colour};
    end
  end

  tmpg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (back_item),
    .queue_empty   (queue_empty),
    .pop           (queue_pop),
    .swap_red_blue (swap_red_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

  // The last pixel of a frame is always the bottom-right raster position.
  a_frame_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_last |->
      out_data.pixel_x == 9'(RASTER_W - 1) && out_data.pixel_y == 8'(RASTER_H - 1))
    else $error("frame_last away from the raster end");

  // No pixel appears in the cycle after a reset cycle.
  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    queue_push |-> !queue_full)
    else $error("push into a full queue");

  // A request pushed into an empty queue is taken by the back end in the
  // next cycle, unless a pixel is then held at the output.
  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    queue_push && queue_empty && !out_valid |=> queue_pop || (out_valid && !out_ready))
    else $error("queued request not taken by the back end");

endmodule

@@ tb/sv/tb_text_mode_pixel_generator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the text-mode pixel generator: a raster, store and
// cursor predictor checks every pixel the block puts out. Depends on tmpg_pkg
// and on the text_mode_pixel_generator top level.
module tb_text_mode_pixel_generator;
  import tmpg_pkg::*;

  localparam int CYCLE_LIMIT    = 200_000;
  localparam int DRAIN_CYCLES   = 32;
  localparam int MAX_REPORTS    = 10;
  // Glyphs are loaded for characters 0-15 and 240-255 only; every text word
  // the bench writes uses one of them.
  localparam int FONT_CHARS     = 32;
  // The run stays within the first cell row; two rows are loaded for margin.
  localparam int LOADED_CELLS   = 2 * TEXT_COLUMNS;
  localparam int CASE_REQUESTS  = 40;
  localparam int PHASE_REQUESTS = 170;

  // Every input of the block holds a known value from time zero.
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_req_t    in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  pixel_t     out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  text_mode_pixel_generator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: our own copy of the three stores, the raster position,
  // the blink logic and the configuration registers.
  logic [15:0] cell_words [CELL_COUNT];
  logic [7:0]  glyph_rows [FONT_DEPTH];
  logic [31:0] palette    [PALETTE_DEPTH];
  int unsigned raster_x;
  int unsigned raster_y;
  int unsigned blink_frames;
  bit          cursor_visible;
  cursor_cfg_t cursor;
  bit          swap_rb;

  // Pixels predicted at request acceptance, oldest first.
  pixel_t pixel_expect_q[$];

  // Statistics and failure accounting.
  int mismatches     = 0;
  int pixels_checked = 0;
  int cursor_pixels  = 0;
  int requests_sent  = 0;
  int store_writes   = 0;
  int reg_writes     = 0;
  int cycle_count    = 0;

  // Pacing knobs. The sender works in bursts separated by gaps; the receiver
  // drops ready for stretches of its own choosing.
  int gap_max;
  int burst_max;
  int stall_pct;
  int stall_max;
  int burst_left = 0;
  int stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost pixel ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels still expected",
               cycle_count, pixel_expect_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side. All inputs change only through nonblocking assignments at the
  // rising edge, so everything sampled right after the edge is the value that
  // the block saw at that edge.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(stall_max - 1);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: each accepted pixel is compared with the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pixel_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected pixel colour=%h x=%0d y=%0d last=%b",
                   out_data.pixel_colour, out_data.pixel_x, out_data.pixel_y,
                   out_data.frame_last);
      end else begin
        want = pixel_expect_q.pop_front();
        pixels_checked++;
        if (out_data.pixel_colour !== want.pixel_colour ||
            out_data.pixel_x !== want.pixel_x ||
            out_data.pixel_y !== want.pixel_y ||
            out_data.frame_last !== want.frame_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Pixel mismatch: expected colour=%h x=%0d y=%0d last=%b,",
                     want.pixel_colour, want.pixel_x, want.pixel_y, want.frame_last);
            $display("  got colour=%h x=%0d y=%0d last=%b",
                     out_data.pixel_colour, out_data.pixel_x, out_data.pixel_y,
                     out_data.frame_last);
          end
        end
      end
    end
  end

  // Applies one accepted request to the predictor. Loads update the stores;
  // a tick computes the pixel at the current raster position and advances it.
  function automatic void predict_request(input in_req_t req);
    pixel_t      px;
    int unsigned cell_col;
    int unsigned cell_row;
    logic [2:0]  glyph_line;
    logic [2:0]  glyph_bit;
    logic [15:0] word;
    logic [7:0]  glyph;
    logic [31:0] colour;
    case (req.opcode)
      OP_TEXT: begin
        store_writes++;
        // Writes past the last cell are dropped.
        if (req.write_address < CELL_COUNT)
          cell_words[req.write_address[CELL_AW-1:0]] = req.write_value[15:0];
      end
      OP_FONT: begin
        store_writes++;
        glyph_rows[req.write_address] = req.write_value[7:0];
      end
      OP_PALETTE: begin
        store_writes++;
        if (req.write_address < PALETTE_DEPTH)
          palette[req.write_address[PAL_AW-1:0]] = req.write_value;
      end
      OP_TICK: begin
        // At the top-left pixel the blink logic decides whether the cursor is
        // shown in this frame. The counter steps by two from 8 to 15, which
        // gives eight shown frames and five hidden ones.
        if (raster_x == 0 && raster_y == 0) begin
          if (cursor.enable) begin
            cursor_visible = (blink_frames < 8);
            if (blink_frames < 8)
              blink_frames += 1;
            else if (blink_frames < 16)
              blink_frames += 2;
            else
              blink_frames = 0;
          end else begin
            cursor_visible = 1'b0;
          end
        end
        cell_col   = raster_x >> 3;
        cell_row   = raster_y >> 3;
        glyph_line = raster_y[2:0];
        glyph_bit  = raster_x[2:0];
        word       = cell_words[CELL_AW'(cell_col + TEXT_COLUMNS * cell_row)];
        glyph      = glyph_rows[{word[7:0], glyph_line}];
        // Bit 7 of a glyph row is its leftmost pixel.
        colour = glyph[3'd7 - glyph_bit] ? palette[word[11:8]] : palette[word[15:12]];
        // The cursor band needs a visible frame, a cell inside the grid and a
        // non-empty line range.
        if (cursor_visible && cursor.enable &&
            cursor.row < TEXT_ROWS && cursor.column < TEXT_COLUMNS &&
            cursor.first_line <= cursor.last_line &&
            cell_row == cursor.row && cell_col == cursor.column &&
            glyph_line >= cursor.first_line && glyph_line <= cursor.last_line) begin
          colour = palette[cursor.colour];
          cursor_pixels++;
        end
        if (swap_rb)
          colour = {colour[31:24], colour[7:0], colour[15:8], colour[23:16]};
        px.pixel_colour = colour;
        px.pixel_x      = raster_x[8:0];
        px.pixel_y      = raster_y[7:0];
        px.frame_last   = (raster_x == RASTER_W - 1 && raster_y == RASTER_H - 1);
        pixel_expect_q.push_back(px);
        raster_x++;
        if (raster_x >= RASTER_W) begin
          raster_x = 0;
          raster_y++;
          if (raster_y >= RASTER_H)
            raster_y = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic cursor_cfg_t cursor_setup(input bit enable, input int column,
                                               input int row, input int first,
                                               input int last, input int colour);
    cursor_cfg_t c;
    c.enable     = enable;
    c.column     = column[7:0];
    c.row        = row[7:0];
    c.first_line = first[2:0];
    c.last_line  = last[2:0];
    c.colour     = colour[3:0];
    return c;
  endfunction

  // Maps 0-15 to characters 0-15 and 16-31 to characters 240-255.
  function automatic logic [7:0] font_char(input logic [4:0] pick);
    return {{4{pick[4]}}, pick[3:0]};
  endfunction

  // A text word with random colours and a character whose glyph is loaded.
  function automatic logic [31:0] random_text_word();
    logic [31:0] v;
    v      = $urandom;
    v[7:0] = font_char(5'($urandom));
    return v;
  endfunction

  // Cell position of the raster and the next cell that it will enter.
  function automatic int aim_row();
    return int'(raster_y >> 3);
  endfunction

  function automatic int aim_col();
    return int'(((raster_x >> 3) + 1) % TEXT_COLUMNS);
  endfunction

  function automatic int aim_line();
    return int'(raster_y & 7);
  endfunction

  // A random load request. Text and palette addresses sometimes land past the
  // end of their store, where the block must drop them.
  function automatic in_req_t random_store_write();
    in_req_t r;
    r.write_value = $urandom;
    case ($urandom_range(2))
      0: begin
        r.opcode        = OP_TEXT;
        r.write_value   = random_text_word();
        r.write_address = ($urandom_range(15) == 0)
                        ? WADDR_W'($urandom_range(2047, CELL_COUNT))
                        : WADDR_W'($urandom_range(CELL_COUNT - 1));
      end
      1: begin
        r.opcode        = OP_FONT;
        r.write_address = WADDR_W'($urandom_range(FONT_DEPTH - 1));
      end
      default: begin
        r.opcode        = OP_PALETTE;
        r.write_address = ($urandom_range(7) == 0)
                        ? WADDR_W'($urandom_range(2047, PALETTE_DEPTH))
                        : WADDR_W'($urandom_range(PALETTE_DEPTH - 1));
      end
    endcase
    return r;
  endfunction

  // Address and value of a tick are don't-care; the mixed stream fills them with random bits.
  function automatic in_req_t make_request(input opcode_t op, input int unsigned addr,
                                           input logic [31:0] value);
    in_req_t r;
    r.opcode        = op;
    r.write_address = addr[WADDR_W-1:0];
    r.write_value   = value;
    return r;
  endfunction

  task automatic set_pacing(input int gaps, input int bursts, input int stall_chance,
                            input int stall_len);
    gap_max   = gaps;
    burst_max = bursts;
    stall_pct = stall_chance;
    stall_max = stall_len;
  endtask

  // Sends one request and waits for its acceptance. Valid stays high between
  // back-to-back requests; it only drops for the gap before a new burst.
  task automatic send_request(input in_req_t req);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(burst_max, 1);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    requests_sent++;
    predict_request(req);
  endtask

  // One request of a mixed stream: a random load with the given chance in
  // percent, otherwise a pixel tick.
  task automatic send_one(input int write_pct);
    if ($urandom_range(99) < write_pct)
      send_request(random_store_write());
    else
      send_request(make_request(OP_TICK, $urandom_range(2047), $urandom));
  endtask

  task automatic send_mixed(input int count, input int write_pct);
    repeat (count) send_one(write_pct);
  endtask

  // Brings the block to idle: no request pending, every pixel received, and a
  // few more cycles so that trailing loads leave the pipeline.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      CFG_CURSOR_ENABLE: cursor.enable     = value[0];
      CFG_CURSOR_COLUMN: cursor.column     = value;
      CFG_CURSOR_ROW:    cursor.row        = value;
      CFG_CURSOR_FIRST:  cursor.first_line = value[2:0];
      CFG_CURSOR_LAST:   cursor.last_line  = value[2:0];
      CFG_CURSOR_COLOUR: cursor.colour     = value[3:0];
      CFG_SWAP_RED_BLUE: swap_rb           = value[0];
      default: ;
    endcase
  endtask

  // Idles the block and writes all seven registers. Bits above a register's
  // width carry noise, since the block must mask them off.
  task automatic program_cursor(input cursor_cfg_t c, input bit swap);
    logic [7:0] noise;
    drain_pipeline();
    noise = 8'($urandom);
    write_register(CFG_CURSOR_ENABLE, {noise[7:1], c.enable});
    write_register(CFG_CURSOR_COLUMN, c.column);
    write_register(CFG_CURSOR_ROW, c.row);
    write_register(CFG_CURSOR_FIRST, {noise[4:0], c.first_line});
    write_register(CFG_CURSOR_LAST, {noise[7:3], c.last_line});
    write_register(CFG_CURSOR_COLOUR, {noise[3:0], c.colour});
    write_register(CFG_SWAP_RED_BLUE, {noise[6:0], swap});
    cfg_valid <= 1'b0;
  endtask

  // The cursor is enabled before the first tick so that frame zero shows it.
  task automatic test_initial_config();
    program_cursor(cursor_setup(1'b1, 0, 0, 0, 7, 3), 1'b0);
  endtask

  // Loads the whole palette, the glyphs of every character the bench uses and
  // the cells that the raster passes, so that no tick reads an unwritten entry.
  task automatic test_store_load();
    for (int i = 0; i < PALETTE_DEPTH; i++)
      send_request(make_request(OP_PALETTE, i, $urandom));
    for (int i = 0; i < FONT_CHARS; i++)
      for (int gl = 0; gl < 8; gl++)
        send_request(make_request(OP_FONT, 32'({font_char(5'(i)), 3'(gl)}), $urandom));
    for (int i = 0; i < LOADED_CELLS; i++)
      send_request(make_request(OP_TEXT, i, random_text_word()));
  endtask

  // Short directed run: dropped loads at the end of the address range, value
  // extremes, and the first pixels of frame zero with the cursor on cell 0.
  task automatic test_directed();
    send_request(make_request(OP_TEXT, CELL_COUNT, 32'hFFFF_FFFF));
    send_request(make_request(OP_TEXT, 2047, 32'h0000_0000));
    send_request(make_request(OP_PALETTE, PALETTE_DEPTH, 32'hFFFF_FFFF));
    send_request(make_request(OP_PALETTE, 2047, 32'h0000_0000));
    send_request(make_request(OP_FONT, 2047, 32'hFFFF_FFA5));
    send_request(make_request(OP_FONT, 0, 32'h0000_0000));
    send_request(make_request(OP_PALETTE, 15, 32'hFFFF_FFFF));
    send_request(make_request(OP_PALETTE, 0, 32'h0000_0000));
    send_request(make_request(OP_PALETTE, 3, 32'h00FF_00AA));
    // Cell 1: character 255, ink 0, paper 15. Cell 2: character 0, ink 15.
    send_request(make_request(OP_TEXT, 1, 32'hFFFF_F0FF));
    send_request(make_request(OP_TEXT, 2, 32'h0000_0F00));
    repeat (14) send_request(make_request(OP_TICK, 0, 32'h0000_0000));
  endtask

  // One cursor setting followed by a short mixed stream.
  task automatic run_cursor_case(input bit enable, input int column, input int row,
                                 input int first, input int last, input int colour,
                                 input bit swap);
    program_cursor(cursor_setup(enable, column, row, first, last, colour), swap);
    send_mixed(CASE_REQUESTS, 10);
  endtask

  // Most cases put the cursor on the next cell that the raster enters.
  task automatic test_cursor_sweep();
    set_pacing(5, 20, 25, 4);
    run_cursor_case(1'b1, aim_col(), aim_row(), 0, 7, 15, 1'b0);
    // The last column, then the wrap to the start of the next line.
    while ((raster_x >> 3) != TEXT_COLUMNS - 2) send_one(10);
    run_cursor_case(1'b1, TEXT_COLUMNS - 1, aim_row(), 0, 7, 0, 1'b1);
    // Columns and rows just past the grid, and the largest values.
    run_cursor_case(1'b1, TEXT_COLUMNS, aim_row(), 0, 7, 5, 1'b0);
    run_cursor_case(1'b1, 255, aim_row(), 2, 5, 9, 1'b1);
    run_cursor_case(1'b1, aim_col(), TEXT_ROWS, 0, 7, 1, 1'b0);
    run_cursor_case(1'b1, aim_col(), 255, 0, 7, 1, 1'b0);
    // First line after last line: an empty band draws nothing.
    run_cursor_case(1'b1, aim_col(), aim_row(), 3, 0, 3, 1'b0);
    // A band of one line on the line that the raster is in.
    run_cursor_case(1'b1, aim_col(), aim_row(), aim_line(), aim_line(), 14, 1'b1);
    run_cursor_case(1'b0, aim_col(), aim_row(), 0, 7, 14, 1'b0);
    run_cursor_case(1'b1, $urandom_range(TEXT_COLUMNS - 1), aim_row(),
                    $urandom_range(7), $urandom_range(7), $urandom_range(15),
                    1'($urandom_range(1)));
  endtask

  // Random traffic in several phases, each with its own cursor setting and
  // pacing; one phase runs with no idling on either side.
  task automatic test_random_traffic();
    cursor_cfg_t c;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1)
        set_pacing(0, 1, 0, 1);
      else
        set_pacing($urandom_range(8), $urandom_range(32, 1), $urandom_range(40),
                   $urandom_range(6, 1));
      c.enable     = ($urandom_range(3) != 0);
      c.row        = ($urandom_range(1) != 0) ? 8'(aim_row()) : 8'($urandom_range(255));
      c.column     = ($urandom_range(1) != 0) ? 8'(aim_col()) : 8'($urandom_range(255));
      c.first_line = 3'($urandom_range(7));
      c.last_line  = 3'($urandom_range(7));
      c.colour     = 4'($urandom_range(15));
      program_cursor(c, 1'($urandom_range(1)));
      send_mixed(PHASE_REQUESTS, 15);
    end
  endtask

  initial begin
    cursor           = '0;
    cursor.last_line = 3'd7;
    swap_rb          = 1'b0;
    raster_x         = 0;
    raster_y         = 0;
    blink_frames     = 0;
    cursor_visible   = 1'b0;
    set_pacing(6, 24, 20, 4);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_initial_config();
    test_store_load();
    test_directed();
    test_cursor_sweep();
    test_random_traffic();
    drain_pipeline();

    $display("Checked %0d pixels over the first %0d raster lines, %0d under the cursor;",
             pixels_checked, raster_y + 1, cursor_pixels);
    $display("sent %0d requests with %0d store loads, and %0d register writes.",
             requests_sent, store_writes, reg_writes);
    if (mismatches == 0 && pixel_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d pixels never received",
               mismatches, pixel_expect_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
